### rtl/sppe_pkg.sv
// Shared constants and helpers for the stereo ping-pong echo.
// No dependencies; imported by every module of the block.
package sppe_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd2;

  localparam int CFG_DATA_W    = 16;
  localparam int DELAY_FIELD_W = 13;
  localparam int GAIN_W        = 16;

  localparam int MAX_DELAY_DEF    = 4096;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int DELAY_RESET = 10;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  // Zero reads as one, anything above the line depth saturates to it
  function automatic logic [31:0] clamp_delay(logic [DELAY_FIELD_W-1:0] v, int unsigned depth);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return 32'd1;
    end
    if (w > depth) begin
      return depth;
    end
    return w;
  endfunction

endpackage

### rtl/stereo_ping_pong_echo.sv
// Stereo ping-pong echo top level: config registers, two-stage pipeline,
// output register. Depends on sppe_pkg, sppe_ptr, sppe_line, sppe_mix.
//
// The block accepts one stereo pair per clock while the output side takes
// every beat, and returns one pair per pair accepted, via the output register.
// Stage one issues the line reads and advances the ring pointers; stage two
// scales the popped echo, adds it to the input, saturates, writes the result
// into the opposite channel's line and loads the output register. The left
// result feeds the right line and the right result the left line. A one-sample
// delay is carried by forwarding the write of the previous beat straight into
// the mixer, so the multiply-add-saturate in stage two sets the clock period.
// Input is held off only while stage two and the output register are both
// full. Writing a delay register restarts that channel's line, so echoes begin
// again after the new delay; write configuration only while the block is idle.
// Line memories start with undefined contents and need no clearing pass: an
// entry is popped only after it was written. Delays of zero read as one, and
// delays above MAX_DELAY saturate to it. Gains above 32768 apply as written.
module stereo_ping_pong_echo #(
  parameter int MAX_DELAY    = sppe_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_WIDTH = sppe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]      right_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      left_out,
  output logic signed [SAMPLE_WIDTH-1:0]      right_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sppe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sppe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sppe_pkg::*;

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW = $clog2(MAX_DELAY + 1);
  localparam int SW = SAMPLE_WIDTH;

  logic              in_acc;
  logic              b_adv;
  logic              cfg_acc;
  logic [GAIN_W-1:0] gain;

  logic              pop_l, pop_r;
  logic [AW-1:0]     raddr_l, raddr_r, waddr_l, waddr_r;

  // Stage two registers
  logic              b_valid;
  logic signed [SW-1:0] b_left_in, b_right_in;
  logic              b_pop_l, b_pop_r;
  logic [AW-1:0]     b_waddr_l, b_waddr_r;

  logic signed [SW-1:0] echo_l, echo_r;
  logic signed [SW-1:0] mix_l, mix_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Stage two drains whenever the output register is empty or being taken
  assign b_adv    = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || b_adv;
  assign in_acc   = in_valid && in_ready;

  // Feedback gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_acc && (cfg_index == CFG_FEEDBACK_GAIN)) begin
      gain <= cfg_data[GAIN_W-1:0];
    end
  end

  sppe_ptr #(.MAX_DELAY(MAX_DELAY), .AW(AW), .CW(CW)) u_ptr_l (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_acc && (cfg_index == CFG_LEFT_DELAY)),
    .cfg_delay (cfg_data[DELAY_FIELD_W-1:0]),
    .adv       (in_acc),
    .pop       (pop_l),
    .raddr     (raddr_l),
    .waddr     (waddr_l)
  );

  sppe_ptr #(.MAX_DELAY(MAX_DELAY), .AW(AW), .CW(CW)) u_ptr_r (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_acc && (cfg_index == CFG_RIGHT_DELAY)),
    .cfg_delay (cfg_data[DELAY_FIELD_W-1:0]),
    .adv       (in_acc),
    .pop       (pop_r),
    .raddr     (raddr_r),
    .waddr     (waddr_r)
  );

  // Capture the accepted beat into stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_acc) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_left_in  <= left_in;
      b_right_in <= right_in;
      b_pop_l    <= pop_l;
      b_pop_r    <= pop_r;
      b_waddr_l  <= waddr_l;
      b_waddr_r  <= waddr_r;
    end
  end

  // Left line holds right results; right line holds left results
  sppe_line #(.MAX_DELAY(MAX_DELAY), .AW(AW), .SAMPLE_WIDTH(SW)) u_line_l (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (raddr_l),
    .wr_en   (b_adv),
    .wr_addr (b_waddr_l),
    .wr_data (mix_r),
    .rd_data (echo_l)
  );

  sppe_line #(.MAX_DELAY(MAX_DELAY), .AW(AW), .SAMPLE_WIDTH(SW)) u_line_r (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (raddr_r),
    .wr_en   (b_adv),
    .wr_addr (b_waddr_r),
    .wr_data (mix_l),
    .rd_data (echo_r)
  );

  sppe_mix #(.SAMPLE_WIDTH(SW)) u_mix_l (
    .sample_in  (b_left_in),
    .echo       (echo_l),
    .gain       (gain),
    .pop        (b_pop_l),
    .sample_out (mix_l)
  );

  sppe_mix #(.SAMPLE_WIDTH(SW)) u_mix_r (
    .sample_in  (b_right_in),
    .echo       (echo_r),
    .gain       (gain),
    .pop        (b_pop_r),
    .sample_out (mix_r)
  );

  // Output register: load on drain, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      left_out  <= mix_l;
      right_out <= mix_r;
    end
  end

endmodule

### rtl/sppe_ptr.sv
// Ring pointers, fill count and delay register of one delay line.
// Depends on sppe_pkg.
module sppe_ptr #(
  parameter int MAX_DELAY = sppe_pkg::MAX_DELAY_DEF,
  parameter int AW        = 12,
  parameter int CW        = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr,
  input  logic [sppe_pkg::DELAY_FIELD_W-1:0] cfg_delay,
  input  logic                             adv,
  output logic                             pop,
  output logic [AW-1:0]                    raddr,
  output logic [AW-1:0]                    waddr
);
  import sppe_pkg::*;

  localparam int RESET_DELAY = (DELAY_RESET > MAX_DELAY) ? MAX_DELAY : DELAY_RESET;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_DELAY - 1);

  logic [CW-1:0] delay;
  logic [CW-1:0] count;
  logic [AW-1:0] rpos;
  logic [AW-1:0] wpos;

  function automatic logic [AW-1:0] step_pos(logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  assign pop   = (count == delay);
  assign raddr = rpos;
  assign waddr = wpos;

  // A full line pops and pushes in the same beat, so its count holds
  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= CW'(RESET_DELAY);
      count <= '0;
      rpos  <= '0;
      wpos  <= '0;
    end else if (cfg_wr) begin
      delay <= CW'(clamp_delay(cfg_delay, MAX_DELAY));
      count <= '0;
      rpos  <= '0;
      wpos  <= '0;
    end else if (adv) begin
      wpos <= step_pos(wpos);
      if (pop) begin
        rpos <= step_pos(rpos);
      end else begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

### rtl/sppe_line.sv
// Delay line memory: one write port, one registered read port, with
// forwarding of a write that lands on the entry being read. Depends on sppe_pkg.
module sppe_line #(
  parameter int MAX_DELAY    = sppe_pkg::MAX_DELAY_DEF,
  parameter int AW           = 12,
  parameter int SAMPLE_WIDTH = sppe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [SAMPLE_WIDTH-1:0] wr_data,
  output logic [SAMPLE_WIDTH-1:0] rd_data
);
  import sppe_pkg::*;

  logic [SAMPLE_WIDTH-1:0] mem [MAX_DELAY];
  logic [SAMPLE_WIDTH-1:0] mem_q;
  logic [SAMPLE_WIDTH-1:0] wr_last;
  logic                    fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Same-edge write to the read entry: memory returns old data, so take the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_last <= wr_data;
    end
  end

  assign rd_data = fwd ? wr_last : mem_q;

endmodule

### rtl/sppe_mix.sv
// One channel mixer: Q1.15 echo scaling, add to input, saturate.
// Depends on sppe_pkg.
module sppe_mix #(
  parameter int SAMPLE_WIDTH = sppe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic signed [SAMPLE_WIDTH-1:0]   echo,
  input  logic [sppe_pkg::GAIN_W-1:0]      gain,
  input  logic                             pop,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out
);
  import sppe_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + GAIN_W + 1;

  logic signed [PW-1:0]   echo_x;
  logic signed [PW-1:0]   gain_x;
  logic signed [PW-1:0]   prod;
  logic signed [SW+1:0]   scaled;
  logic signed [SW+2:0]   sum;
  logic                   sat_hi;
  logic                   sat_lo;

  assign echo_x = {{(GAIN_W+1){echo[SW-1]}}, echo};
  assign gain_x = {{(SW+1){1'b0}}, gain};
  assign prod   = echo_x * gain_x;
  // Arithmetic shift by 15 rounds toward minus infinity
  assign scaled = prod[SW+16:15];
  assign sum    = {{3{sample_in[SW-1]}}, sample_in} + {scaled[SW+1], scaled};
  assign sat_hi = !sum[SW+2] && (sum[SW+1:SW-1] != 3'b000);
  assign sat_lo = sum[SW+2] && (sum[SW+1:SW-1] != 3'b111);

  always_comb begin
    priority if (!pop) begin
      sample_out = sample_in;
    end else if (sat_hi) begin
      sample_out = {1'b0, {(SW-1){1'b1}}};
    end else if (sat_lo) begin
      sample_out = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sample_out = sum[SW-1:0];
    end
  end

endmodule

### rtl/sppe_checker.sv
// Port-level checks for the stereo ping-pong echo, bound to the top level.
// Depends on sppe_pkg and stereo_ping_pong_echo.
module sppe_checker #(
  parameter int SAMPLE_WIDTH = sppe_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic signed [SAMPLE_WIDTH-1:0]  left_in,
  input logic signed [SAMPLE_WIDTH-1:0]  right_in,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [SAMPLE_WIDTH-1:0]  left_out,
  input logic signed [SAMPLE_WIDTH-1:0]  right_out
);
  import sppe_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("result beat changed while stalled");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(left_in) && $stable(right_in))
    else $error("input beat changed while stalled");

  // Input backpressure only comes from a pending result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input held off with no result pending");

  // A fresh result follows an accepted input beat via stage two and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input beat");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stereo_ping_pong_echo sppe_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sppe_checker (.*);

### dv/tb_stereo_ping_pong_echo.sv
// Self-checking testbench for the stereo ping-pong echo block.
// Depends on sppe_pkg and stereo_ping_pong_echo; a scoreboard class predicts
// each output pair from the accepted input pairs and the register settings.
module tb_stereo_ping_pong_echo;

  import sppe_pkg::*;

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int MAX_DEPTH = MAX_DELAY_DEF;
  localparam int RING_AW   = $clog2(MAX_DEPTH);

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Corner values for the directed beats
  localparam logic signed [SW-1:0] EDGE_VALS [8] = '{
    16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd16384, -16'sd16384, 16'sd12345
  };

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } sample_pair_t;

  // Tracks both delay lines and holds the output pairs still to come
  class echo_tracker;
    logic signed [SW-1:0] left_ring [MAX_DEPTH];
    logic signed [SW-1:0] right_ring [MAX_DEPTH];
    bit [RING_AW-1:0]     left_wr, left_rd, right_wr, right_rd;
    bit [RING_AW:0]       left_fill, right_fill;
    bit [RING_AW:0]       left_len, right_len;
    bit [GAIN_W-1:0]      gain;
    sample_pair_t         expected_pairs [$];
    int                   mismatches;
    int                   checked;

    function new();
      left_len   = (RING_AW+1)'(DELAY_RESET);
      right_len  = (RING_AW+1)'(DELAY_RESET);
      gain       = GAIN_RESET;
      left_wr    = '0;
      left_rd    = '0;
      left_fill  = '0;
      right_wr   = '0;
      right_rd   = '0;
      right_fill = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function bit [RING_AW:0] clamp_len(logic [CFG_DATA_W-1:0] raw);
      bit [DELAY_FIELD_W-1:0] v;
      v = raw[DELAY_FIELD_W-1:0];
      if (v == 0) return (RING_AW+1)'(1);
      if (v > MAX_DEPTH) return (RING_AW+1)'(MAX_DEPTH);
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LEFT_DELAY: begin
          left_len  = clamp_len(data);
          left_wr   = '0;
          left_rd   = '0;
          left_fill = '0;
        end
        CFG_RIGHT_DELAY: begin
          right_len  = clamp_len(data);
          right_wr   = '0;
          right_rd   = '0;
          right_fill = '0;
        end
        CFG_FEEDBACK_GAIN: gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Dry sample plus the echo scaled by Q1.15 gain (floor shift), saturated
    function logic signed [SW-1:0] mix(logic signed [SW-1:0] dry, logic signed [SW-1:0] echo);
      longint wet;
      longint hi;
      hi  = (longint'(1) << (SW - 1)) - 1;
      wet = longint'(dry) + ((longint'(echo) * longint'(gain)) >>> 15);
      if (wet > hi) return hi[SW-1:0];
      if (wet < -hi - 1) return {1'b1, {(SW-1){1'b0}}};
      return wet[SW-1:0];
    endfunction

    function void note_pair(logic signed [SW-1:0] l_in, logic signed [SW-1:0] r_in);
      sample_pair_t p;
      p.left  = l_in;
      p.right = r_in;
      // Pop both lines first, then cross-feed the results
      if (left_fill == left_len) begin
        p.left = mix(l_in, left_ring[left_rd]);
        left_rd++;
        left_fill--;
      end
      if (right_fill == right_len) begin
        p.right = mix(r_in, right_ring[right_rd]);
        right_rd++;
        right_fill--;
      end
      if (right_fill < right_len) begin
        right_ring[right_wr] = p.left;
        right_wr++;
        right_fill++;
      end
      if (left_fill < left_len) begin
        left_ring[left_wr] = p.right;
        left_wr++;
        left_fill++;
      end
      expected_pairs.push_back(p);
    endfunction

    function void check_pair(logic signed [SW-1:0] l_got, logic signed [SW-1:0] r_got);
      sample_pair_t want;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: left=%0d right=%0d", l_got, r_got);
        return;
      end
      want = expected_pairs.pop_front();
      checked++;
      if (l_got !== want.left || r_got !== want.right) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output beat %0d: expected left=%0d right=%0d, got left=%0d right=%0d",
                   checked, want.left, want.right, l_got, r_got);
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [SW-1:0]  left_in = '0;
  logic signed [SW-1:0]  right_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SW-1:0]  left_out;
  logic signed [SW-1:0]  right_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_tracker tracker;
  int          send_gap_pct = 18;
  int          recv_gap_pct = 56;
  int          settings_run = 0;
  bit          hold_go = 1'b0;
  logic        rx_hold = 1'b0;

  stereo_ping_pong_echo dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: check every output beat against the oldest prediction, then
  // pick the next ready value. The hold-off process can force ready low.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_pair(left_out, right_out);
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_gap_pct);
  end

  // Long output stall, counted here: once the sender starts offering beats,
  // hold ready low so the pipeline backs up into the input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    wait (in_valid);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (64) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Full-range noise half the time, one of the first four corner values otherwise
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return EDGE_VALS[0];
      1: return EDGE_VALS[1];
      2: return EDGE_VALS[2];
      3: return EDGE_VALS[3];
      default: return SW'($urandom);
    endcase
  endfunction

  // Mostly short delays so echoes show up within a phase; sometimes zero,
  // the maximum, or a field value past the maximum. Upper data bits are junk.
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    logic [CFG_DATA_W-1:0] raw;
    raw = CFG_DATA_W'($urandom);
    case ($urandom_range(9))
      0: raw[DELAY_FIELD_W-1:0] = '0;
      1: raw[DELAY_FIELD_W-1:0] = '1;
      2: raw[DELAY_FIELD_W-1:0] = DELAY_FIELD_W'(MAX_DEPTH);
      3: ;
      default: raw[DELAY_FIELD_W-1:0] = DELAY_FIELD_W'($urandom_range(24, 1));
    endcase
    return raw;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(32768, 0));
    endcase
  endfunction

  // Offer one stereo beat, with an optional idle gap first; hold it until taken
  task automatic send_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    tracker.note_pair(l, r);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // One register beat; the caller drops cfg_valid after its last beat
  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  // Every beat yields one output, so an empty queue means the block is idle
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Reprogram all registers while idle, then stream random beats
  task automatic run_phase(logic [CFG_DATA_W-1:0] ld, logic [CFG_DATA_W-1:0] rd,
                           logic [CFG_DATA_W-1:0] g, int count, bit pause_mid,
                           bit poke_unused);
    settle();
    cfg_beat(CFG_LEFT_DELAY, ld);
    cfg_beat(CFG_RIGHT_DELAY, rd);
    cfg_beat(CFG_FEEDBACK_GAIN, g);
    if (poke_unused) cfg_beat(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_run++;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        // Pause the input until every prediction has been checked
        stop_sending();
        settle();
        @(posedge clk);
      end
      send_pair(pick_sample(), pick_sample());
    end
    stop_sending();
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats on reset settings: corners on both channels, long enough
    // to pass the default delay and see saturating echoes
    for (int i = 0; i < 24; i++) begin
      send_pair(EDGE_VALS[i % 8], EDGE_VALS[(i * 3 + 1) % 8]);
    end
    stop_sending();
    settings_run++;

    // Zero delay reads as one, unity gain
    run_phase(16'd0, 16'd1, 16'd32768, 20, 1'b0, 1'b0);
    // Gain near two, short unequal delays
    run_phase(16'd2, 16'd3, 16'hFFFF, 20, 1'b0, 1'b0);
    // Gain zero: echoes pop but add nothing
    run_phase(16'd5, 16'd1, 16'd0, 20, 1'b0, 1'b1);

    // Random settings: sender-light idling, then receiver-light, then none
    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_gap_pct = 56;
        recv_gap_pct = 18;
      end
      if (p == 8) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_go      = 1'b1;
      end
      run_phase(pick_delay(), pick_delay(), pick_gain(), 28, p == 5, p == 2);
    end

    // Maximum delays on both lines, one written past the maximum; the lines
    // only fill here
    run_phase(16'hFFFF, 16'(MAX_DEPTH), 16'd24576, 40, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    $display("checked %0d output beats over %0d register settings", tracker.checked,
             settings_run);
    $display("idle mixes both ways, a long output stall, an input pause, max delay fill");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sppe_pkg.sv
rtl/sppe_ptr.sv
rtl/sppe_line.sv
rtl/sppe_mix.sv
rtl/stereo_ping_pong_echo.sv
rtl/sppe_checker.sv
dv/tb_stereo_ping_pong_echo.sv
